[src/pta_pkg.sv]
// shared types, constants and saturating helpers for the process time accounting block
package pta_pkg;

  localparam int NUM_PROCS = 8;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int OUT_BITS  = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [OUT_BITS-1:0]  out_t;

  // scheduler event codes on the func port
  localparam logic [2:0] FN_TICK      = 3'd0;
  localparam logic [2:0] FN_RUNNING   = 3'd1;
  localparam logic [2:0] FN_READY     = 3'd2;
  localparam logic [2:0] FN_BLOCKED   = 3'd3;
  localparam logic [2:0] FN_EXIT_RDY  = 3'd4;
  localparam logic [2:0] FN_EXIT_BLK  = 3'd5;
  localparam logic [2:0] FN_TERM      = 3'd6;
  localparam logic [2:0] FN_READ      = 3'd7;

  // classified operations handed from front to back
  typedef enum logic [3:0] {
    OP_TICK,
    OP_RUN,
    OP_READY,
    OP_BLOCK,
    OP_EXIT_RDY,
    OP_EXIT_BLK,
    OP_TERM,
    OP_READ,
    OP_READ_NIL
  } op_e;

  typedef struct packed {
    op_e  op;
    idx_t idx;
  } item_t;

  // head of the queue as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  localparam time_t TIME_MAX = '1;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic time_t sat_inc(time_t a);
    return (a == TIME_MAX) ? TIME_MAX : a + time_t'(1);
  endfunction

  // low output bits of a counter, zero-extended when the counter is narrower
  function automatic out_t to_out(time_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_BITS-1:0];
  endfunction

endpackage

[src/process_time_accounting.sv]
// top level of the per-process time accounting block
// an item is taken at a clock edge with start high and busy low, one per cycle
// a read result is strobed on valid_o for one cycle, after the front register, queue and two read stages
// an exit event on an armed interval holds the back part in its interval-add state before the next pop
// the receiver cannot stall: busy rises only when the four-entry queue backs up
// reset is asynchronous and clears time, counters and flags at once; stamps are not reset
module process_time_accounting
  import pta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [2:0]  process_id_i,
  output logic        valid_o,
  output logic [31:0] cpu_ticks_o,
  output logic [31:0] wait_ticks_o,
  output logic [31:0] io_ticks_o,
  output logic [31:0] turnaround_o,
  output logic [31:0] finish_stamp_o,
  output logic        done_res_o
);

  logic  push;
  logic  pop;
  logic  full;
  item_t item;
  head_t head;

  // accept and classify
  pta_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .func_i       (func_i),
    .process_id_i (process_id_i),
    .full_i       (full),
    .busy_o       (busy),
    .push_o       (push),
    .item_o       (item)
  );

  // item queue
  pta_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // execute and report
  pta_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .cpu_ticks_o    (cpu_ticks_o),
    .wait_ticks_o   (wait_ticks_o),
    .io_ticks_o     (io_ticks_o),
    .turnaround_o   (turnaround_o),
    .finish_stamp_o (finish_stamp_o),
    .done_res_o     (done_res_o)
  );

endmodule

[src/pta_front.sv]
// front part: accepts events, classifies them and hands them to the queue
module pta_front
  import pta_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] func_i,
  input  logic [2:0] process_id_i,
  input  logic       full_i,
  output logic       busy_o,
  output logic       push_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  item_t cls;
  logic  keep;
  logic  accept;
  logic  pid_ok;
  logic [7:0] pid8;

  // hold off only while a classified item waits on a full queue
  assign busy_o = valid_q & full_i;
  assign accept = start_i & ~busy_o;
  assign push_o = valid_q & ~full_i;
  assign item_o = item_q;

  // classify the event and drop those that change nothing
  always_comb begin
    pid8   = 8'(process_id_i);
    pid_ok = (32'(process_id_i) < NUM_PROCS);
    cls.idx = pid8[IDX_W-1:0];
    keep    = pid_ok;
    case (func_i)
      FN_TICK: begin
        cls.op = OP_TICK;
        keep   = 1'b1;
      end
      FN_RUNNING:  cls.op = OP_RUN;
      FN_READY:    cls.op = OP_READY;
      FN_BLOCKED:  cls.op = OP_BLOCK;
      FN_EXIT_RDY: cls.op = OP_EXIT_RDY;
      FN_EXIT_BLK: cls.op = OP_EXIT_BLK;
      FN_TERM:     cls.op = OP_TERM;
      FN_READ: begin
        cls.op = pid_ok ? OP_READ : OP_READ_NIL;
        keep   = 1'b1;
      end
      default: begin
        cls.op = OP_TICK;
        keep   = 1'b0;
      end
    endcase
  end

  // holding register in front of the queue
  always_comb begin
    valid_d = (valid_q & full_i) | (accept & keep);
    item_d  = accept ? cls : item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

[src/pta_fifo.sv]
// short queue of classified items between front and back
module pta_fifo
  import pta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output head_t head_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o      = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue pushed while full");

endmodule

[src/pta_back.sv]
// back part: time tables, event execution and the read result pipeline
module pta_back
  import pta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  head_t head_i,
  output logic  pop_o,
  output logic  valid_o,
  output out_t  cpu_ticks_o,
  output out_t  wait_ticks_o,
  output out_t  io_ticks_o,
  output out_t  turnaround_o,
  output out_t  finish_stamp_o,
  output logic  done_res_o
);

  localparam logic [0:0] S_RUN  = 1'b0;
  localparam logic [0:0] S_EXIT = 1'b1;

  logic [0:0] state_q, state_d;

  time_t now_q, now_d;
  time_t cpu_q [NUM_PROCS];
  time_t cpu_d [NUM_PROCS];
  time_t wait_q [NUM_PROCS];
  time_t wait_d [NUM_PROCS];
  time_t io_q [NUM_PROCS];
  time_t io_d [NUM_PROCS];
  time_t fin_q [NUM_PROCS];
  time_t fin_d [NUM_PROCS];
  time_t rstamp_q [NUM_PROCS];
  time_t bstamp_q [NUM_PROCS];
  logic [NUM_PROCS-1:0] rarm_q, rarm_d;
  logic [NUM_PROCS-1:0] barm_q, barm_d;
  logic [NUM_PROCS-1:0] done_q, done_d;

  // pending interval add
  time_t elap_q, elap_d;
  logic  ex_blk_q, ex_blk_d;
  idx_t  ex_idx_q, ex_idx_d;

  // read pipeline, first stage
  logic  s1_valid_q, s1_valid_d;
  time_t s1_cpu_q, s1_cpu_d;
  time_t s1_wait_q, s1_wait_d;
  time_t s1_io_q, s1_io_d;
  time_t s1_fin_q, s1_fin_d;
  time_t s1_part_q, s1_part_d;
  logic  s1_done_q, s1_done_d;

  logic  valid_q;
  out_t  cpu_o_q, wait_o_q, io_o_q, turn_o_q, fin_o_q;
  logic  done_o_q;

  idx_t               idx;
  logic               stamp_r, stamp_b;
  logic [TIME_BITS:0] diff;
  time_t              stamp_sel;

  assign idx   = head_i.item.idx;
  assign pop_o = head_i.valid && (state_q == S_RUN);

  // elapsed time of the armed interval, zero when the stamp is ahead of now
  always_comb begin
    stamp_sel = (head_i.item.op == OP_EXIT_BLK) ? bstamp_q[idx] : rstamp_q[idx];
    diff      = {1'b0, now_q} - {1'b0, stamp_sel};
  end

  // event execution
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    cpu_d      = cpu_q;
    wait_d     = wait_q;
    io_d       = io_q;
    fin_d      = fin_q;
    rarm_d     = rarm_q;
    barm_d     = barm_q;
    done_d     = done_q;
    elap_d     = elap_q;
    ex_blk_d   = ex_blk_q;
    ex_idx_d   = ex_idx_q;
    stamp_r    = 1'b0;
    stamp_b    = 1'b0;
    s1_valid_d = 1'b0;
    s1_cpu_d   = '0;
    s1_wait_d  = '0;
    s1_io_d    = '0;
    s1_fin_d   = '0;
    s1_part_d  = '0;
    s1_done_d  = 1'b0;
    case (state_q)
      S_RUN: begin
        if (pop_o) begin
          case (head_i.item.op)
            OP_TICK: now_d = sat_inc(now_q);
            OP_RUN:  cpu_d[idx] = sat_inc(cpu_q[idx]);
            OP_READY: begin
              stamp_r     = 1'b1;
              rarm_d[idx] = 1'b1;
            end
            OP_BLOCK: begin
              stamp_b     = 1'b1;
              barm_d[idx] = 1'b1;
            end
            OP_EXIT_RDY, OP_EXIT_BLK: begin
              ex_idx_d = idx;
              ex_blk_d = (head_i.item.op == OP_EXIT_BLK);
              elap_d   = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
              if (ex_blk_d ? barm_q[idx] : rarm_q[idx]) begin
                state_d = S_EXIT;
                if (ex_blk_d) begin
                  barm_d[idx] = 1'b0;
                end else begin
                  rarm_d[idx] = 1'b0;
                end
              end
            end
            OP_TERM: begin
              fin_d[idx]  = now_q;
              done_d[idx] = 1'b1;
            end
            OP_READ: begin
              s1_valid_d = 1'b1;
              s1_cpu_d   = cpu_q[idx];
              s1_wait_d  = wait_q[idx];
              s1_io_d    = io_q[idx];
              s1_fin_d   = fin_q[idx];
              s1_done_d  = done_q[idx];
              s1_part_d  = sat_add(cpu_q[idx], wait_q[idx]);
            end
            OP_READ_NIL: s1_valid_d = 1'b1;
            default: ;
          endcase
        end
      end
      S_EXIT: begin
        state_d = S_RUN;
        if (ex_blk_q) begin
          io_d[ex_idx_q] = sat_add(io_q[ex_idx_q], elap_q);
        end else begin
          wait_d[ex_idx_q] = sat_add(wait_q[ex_idx_q], elap_q);
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  // control state and cleared tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RUN;
      now_q      <= '0;
      rarm_q     <= '0;
      barm_q     <= '0;
      done_q     <= '0;
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        cpu_q[i]  <= '0;
        wait_q[i] <= '0;
        io_q[i]   <= '0;
        fin_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      rarm_q     <= rarm_d;
      barm_q     <= barm_d;
      done_q     <= done_d;
      s1_valid_q <= s1_valid_d;
      valid_q    <= s1_valid_q;
      cpu_q      <= cpu_d;
      wait_q     <= wait_d;
      io_q       <= io_d;
      fin_q      <= fin_d;
    end
  end

  // stamps and payload registers
  always_ff @(posedge clk_i) begin
    if (stamp_r) begin
      rstamp_q[idx] <= now_q;
    end
    if (stamp_b) begin
      bstamp_q[idx] <= now_q;
    end
    elap_q    <= elap_d;
    ex_blk_q  <= ex_blk_d;
    ex_idx_q  <= ex_idx_d;
    s1_cpu_q  <= s1_cpu_d;
    s1_wait_q <= s1_wait_d;
    s1_io_q   <= s1_io_d;
    s1_fin_q  <= s1_fin_d;
    s1_part_q <= s1_part_d;
    s1_done_q <= s1_done_d;
    cpu_o_q   <= to_out(s1_cpu_q);
    wait_o_q  <= to_out(s1_wait_q);
    io_o_q    <= to_out(s1_io_q);
    turn_o_q  <= to_out(sat_add(s1_part_q, s1_io_q));
    fin_o_q   <= to_out(s1_fin_q);
    done_o_q  <= s1_done_q;
  end

  assign valid_o        = valid_q;
  assign cpu_ticks_o    = cpu_o_q;
  assign wait_ticks_o   = wait_o_q;
  assign io_ticks_o     = io_o_q;
  assign turnaround_o   = turn_o_q;
  assign finish_stamp_o = fin_o_q;
  assign done_res_o     = done_o_q;

  a_exit_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXIT) |-> $past(pop_o))
    else $error("interval add without a popped exit item");

  a_no_pop_in_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXIT) |-> !pop_o)
    else $error("item popped during interval add");

endmodule

[verif/process_time_accounting_test.sv]
// self-checking testbench for the process time accounting block: event stream with predicted reads
`timescale 1ns / 100ps

module process_time_accounting_test
  import pta_pkg::*;
;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1950;

  // one scheduler event waiting to be offered
  typedef struct {
    logic [2:0] fn;
    logic [2:0] pid;
    bit         drain;
  } sched_item_t;

  // counters of one process as a read returns them
  typedef struct {
    logic [31:0] cpu_cnt;
    logic [31:0] wait_cnt;
    logic [31:0] io_cnt;
    logic [31:0] turn_cnt;
    logic [31:0] finish_cnt;
    logic        done;
  } acct_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func_i = FN_TICK;
  logic [2:0]  process_id_i = '0;
  logic        valid_o;
  logic [31:0] cpu_ticks_o;
  logic [31:0] wait_ticks_o;
  logic [31:0] io_ticks_o;
  logic [31:0] turnaround_o;
  logic [31:0] finish_stamp_o;
  logic        done_res_o;

  sched_item_t event_queue[$];
  acct_t       pending_reads[$];
  int          mismatches = 0;
  int          items_taken = 0;
  int          idle_cycles = 0;

  // predicted accounting state
  logic [31:0] sys_time = '0;
  logic [31:0] cpu_acc[NUM_PROCS] = '{default: '0};
  logic [31:0] wait_acc[NUM_PROCS] = '{default: '0};
  logic [31:0] io_acc[NUM_PROCS] = '{default: '0};
  logic [31:0] finish_at[NUM_PROCS] = '{default: '0};
  logic [31:0] ready_at[NUM_PROCS] = '{default: '0};
  logic [31:0] blocked_at[NUM_PROCS] = '{default: '0};
  bit          ready_on[NUM_PROCS] = '{default: 1'b0};
  bit          blocked_on[NUM_PROCS] = '{default: 1'b0};
  bit          done_on[NUM_PROCS] = '{default: 1'b0};

  process_time_accounting dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .process_id_i  (process_id_i),
    .valid_o       (valid_o),
    .cpu_ticks_o   (cpu_ticks_o),
    .wait_ticks_o  (wait_ticks_o),
    .io_ticks_o    (io_ticks_o),
    .turnaround_o  (turnaround_o),
    .finish_stamp_o(finish_stamp_o),
    .done_res_o    (done_res_o)
  );

  always #10 clk_i = ~clk_i;

  // counter add that sticks at all ones
  function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
    logic [63:0] s;
    s = 64'(a) + 64'(b);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // time since a stamp, zero if the stamp lies ahead
  function automatic logic [31:0] since(logic [31:0] stamp);
    return (sys_time >= stamp) ? sys_time - stamp : '0;
  endfunction

  // apply one accepted event to the predicted table; a read queues its predicted result
  task automatic account_event(input logic [2:0] fn, input logic [2:0] pid);
    acct_t r;
    case (fn)
      FN_TICK: sys_time = clamp_add(sys_time, 32'd1);
      FN_RUNNING: cpu_acc[pid] = clamp_add(cpu_acc[pid], 32'd1);
      FN_READY: begin
        ready_at[pid] = sys_time;
        ready_on[pid] = 1'b1;
      end
      FN_BLOCKED: begin
        blocked_at[pid] = sys_time;
        blocked_on[pid] = 1'b1;
      end
      FN_EXIT_RDY: if (ready_on[pid]) begin
        wait_acc[pid] = clamp_add(wait_acc[pid], since(ready_at[pid]));
        ready_on[pid] = 1'b0;
      end
      FN_EXIT_BLK: if (blocked_on[pid]) begin
        io_acc[pid] = clamp_add(io_acc[pid], since(blocked_at[pid]));
        blocked_on[pid] = 1'b0;
      end
      FN_TERM: begin
        finish_at[pid] = sys_time;
        done_on[pid] = 1'b1;
      end
      FN_READ: begin
        r.cpu_cnt = cpu_acc[pid];
        r.wait_cnt = wait_acc[pid];
        r.io_cnt = io_acc[pid];
        r.turn_cnt = clamp_add(clamp_add(cpu_acc[pid], wait_acc[pid]), io_acc[pid]);
        r.finish_cnt = finish_at[pid];
        r.done = done_on[pid];
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  // queue an event; two fixed positions hold off until all reads are back
  task automatic push_item(input logic [2:0] fn, input logic [2:0] pid);
    sched_item_t it;
    it.fn = fn;
    it.pid = pid;
    it.drain = (event_queue.size() == 25) || (event_queue.size() == 1000);
    event_queue.push_back(it);
  endtask

  // filler event between an arm and its exit
  task automatic push_filler();
    logic [2:0] fn;
    case ($urandom_range(3))
      0, 1: fn = FN_TICK;
      2: fn = FN_RUNNING;
      default: fn = 3'($urandom_range(7));
    endcase
    push_item(fn, 3'($urandom_range(7)));
  endtask

  // driver: offers items, predicts each one taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= FN_TICK;
      process_id_i <= '0;
    end else begin
      if (start && !busy) begin
        account_event(func_i, process_id_i);
        items_taken++;
      end
      if (!start || !busy) begin
        if (event_queue.size() != 0
            && !(event_queue[0].drain && pending_reads.size() != 0)
            && ((items_taken >= 700 && items_taken < 1000) || $urandom_range(99) >= 34)) begin
          start <= 1'b1;
          func_i <= event_queue[0].fn;
          process_id_i <= event_queue[0].pid;
          void'(event_queue.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor: compares each strobed result with the oldest predicted read
  always @(posedge clk_i) begin
    acct_t e;
    if (rst_ni && valid_o) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cpu %0h", $time, cpu_ticks_o);
        mismatches++;
      end else begin
        e = pending_reads.pop_front();
        check_field("cpu_ticks", e.cpu_cnt, cpu_ticks_o);
        check_field("wait_ticks", e.wait_cnt, wait_ticks_o);
        check_field("io_ticks", e.io_cnt, io_ticks_o);
        check_field("turnaround", e.turn_cnt, turnaround_o);
        check_field("finish_stamp", e.finish_cnt, finish_stamp_o);
        check_field("done_res", 32'(e.done), 32'(done_res_o));
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int n;
    bit blk;
    // directed: reads at reset, exits on disarmed entries, re-arm, repeated termination
    push_item(FN_READ, 3'd0);
    push_item(FN_READ, 3'd7);
    push_item(FN_EXIT_RDY, 3'd1);
    push_item(FN_EXIT_BLK, 3'd1);
    push_item(FN_RUNNING, 3'd1);
    push_item(FN_RUNNING, 3'd1);
    push_item(FN_READY, 3'd1);
    push_item(FN_TICK, 3'd0);
    push_item(FN_TICK, 3'd7);
    push_item(FN_READY, 3'd1);
    push_item(FN_TICK, 3'd5);
    push_item(FN_EXIT_RDY, 3'd1);
    push_item(FN_BLOCKED, 3'd6);
    push_item(FN_TICK, 3'd2);
    push_item(FN_TICK, 3'd3);
    push_item(FN_EXIT_BLK, 3'd6);
    push_item(FN_EXIT_BLK, 3'd6);
    push_item(FN_TERM, 3'd1);
    push_item(FN_TICK, 3'd4);
    push_item(FN_TERM, 3'd1);
    push_item(FN_READ, 3'd1);
    push_item(FN_READ, 3'd6);
    push_item(FN_TERM, 3'd7);
    push_item(FN_READ, 3'd7);
    push_item(FN_READ, 3'd0);
    // random: mostly arm / fill / exit sequences, some loose events
    while (event_queue.size() < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        p = $urandom_range(7);
        blk = 1'($urandom_range(1));
        push_item(blk ? FN_BLOCKED : FN_READY, 3'(p));
        n = $urandom_range(8);
        repeat (n) push_filler();
        push_item(blk ? FN_EXIT_BLK : FN_EXIT_RDY, 3'(p));
        if ($urandom_range(3) == 0) push_item(FN_TERM, 3'(p));
        if ($urandom_range(1) == 1) push_item(FN_READ, 3'(p));
      end else begin
        push_item(3'($urandom_range(7)), 3'($urandom_range(7)));
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait for all items taken and all reads returned
    while (event_queue.size() != 0 || start || pending_reads.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
